/* hdl/crfb_pkg.sv */
// crfb_pkg: shared types and constants for the clipped rectangle fill byte stream
// holds field widths, register defaults, display command codes and the result struct
// no dependencies
package crfb_pkg;

  localparam int COORD_W = 16;
  localparam int COLOUR_W = 16;
  localparam int PANEL_W = 12;
  localparam int BYTES_W = 25;
  localparam int STEP_W = 4;
  localparam int REG_IDX_W = 1;

  localparam int CHUNK_BYTES_DEF = 256;

  localparam logic [PANEL_W-1:0] PANEL_WIDTH_RST = 12'd320;
  localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RST = 12'd240;

  // register indexes on the write port
  localparam logic [REG_IDX_W-1:0] REG_PANEL_WIDTH = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_PANEL_HEIGHT = 1'b1;

  // input commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  // display command bytes
  localparam logic [7:0] DCS_CASET = 8'h2A;
  localparam logic [7:0] DCS_RASET = 8'h2B;
  localparam logic [7:0] DCS_RAMWR = 8'h2C;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       select_release;
    logic       last_byte;
    logic       idle;
  } res_t;

endpackage

/* hdl/crfb_req_if.sv */
// crfb_req_if: request channel, start or pull commands with the rectangle payload
// depends on crfb_pkg for field widths
interface crfb_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic signed [crfb_pkg::COORD_W-1:0]  rect_x;
  logic signed [crfb_pkg::COORD_W-1:0]  rect_y;
  logic signed [crfb_pkg::COORD_W-1:0]  rect_w;
  logic signed [crfb_pkg::COORD_W-1:0]  rect_h;
  logic        [crfb_pkg::COLOUR_W-1:0] fill_colour;

  modport source (output valid, cmd, rect_x, rect_y, rect_w, rect_h, fill_colour,
                  input ready);
  modport sink (input valid, cmd, rect_x, rect_y, rect_w, rect_h, fill_colour,
                output ready);
endinterface

/* hdl/crfb_res_if.sv */
// crfb_res_if: result channel, one display byte with its flags per beat
// no package dependency beyond plain widths
interface crfb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       select_release;
  logic       last_byte;
  logic       idle;

  modport source (output valid, out_byte, is_data, select_release, last_byte, idle,
                  input ready);
  modport sink (input valid, out_byte, is_data, select_release, last_byte, idle,
                output ready);
endinterface

/* hdl/clipped_rect_fill_byte_stream.sv */
// clipped_rect_fill_byte_stream: top level of the rectangle fill byte source
// depends on crfb_pkg, crfb_req_if and crfb_res_if
//
// usage: the req channel carries start beats (cmd 0) with a rectangle and colour,
// and pull beats (cmd 1). a start clips the rectangle to the panel set through
// the write port (wr_en, wr_index, wr_data) and arms a new stream, replacing any
// stream still pending; an empty clip just cancels. a start gives no res beat.
// each pull gives exactly one res beat: the next byte of the stream (0x2A plus
// column bounds, 0x2B plus row bounds, 0x2C, then colour bytes high first) with
// its data/command, select release and last flags, or an idle beat when nothing
// is pending.
// a pull's byte is registered in out_res, or in the skid stage while res stalls.
// throughput: one req beat per cycle unless the skid is full; the byte comes
// straight from the header step and pixel counters, and the pixel byte count is
// multiplied out in the cycle after a start, well before the header is done.
// the result register is backed by a one-entry skid stage, so req keeps moving
// for one beat while res stalls; req.ready drops only when the skid is full.
// reset (synchronous, active high) idles the stream, empties both output stages
// and sets the panel to 320 by 240.
module clipped_rect_fill_byte_stream #(
  parameter int CHUNK_BYTES = crfb_pkg::CHUNK_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [crfb_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [crfb_pkg::PANEL_W-1:0]    wr_data,
  crfb_req_if.sink                        req,
  crfb_res_if.source                      res
);

  localparam int CHUNK_W = $clog2(CHUNK_BYTES);
  localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNK_BYTES - 1);
  localparam int PW = crfb_pkg::PANEL_W;
  localparam int SW = 19;

  // header steps
  localparam logic [3:0] HDR_CASET = 4'd0;
  localparam logic [3:0] HDR_XS_HI = 4'd1;
  localparam logic [3:0] HDR_XS_LO = 4'd2;
  localparam logic [3:0] HDR_XE_HI = 4'd3;
  localparam logic [3:0] HDR_XE_LO = 4'd4;
  localparam logic [3:0] HDR_RASET = 4'd5;
  localparam logic [3:0] HDR_YS_HI = 4'd6;
  localparam logic [3:0] HDR_YS_LO = 4'd7;
  localparam logic [3:0] HDR_YE_HI = 4'd8;
  localparam logic [3:0] HDR_YE_LO = 4'd9;
  localparam logic [3:0] HDR_RAMWR = 4'd10;
  localparam logic [3:0] HDR_DONE = 4'd11;

  logic [PW-1:0] panel_width;
  logic [PW-1:0] panel_height;

  logic [PW-1:0] col_start, col_end, row_start, row_end;
  logic [PW-1:0] clip_w, clip_h;
  logic [crfb_pkg::COLOUR_W-1:0] held_colour;
  logic [crfb_pkg::STEP_W-1:0] header_step;
  logic [crfb_pkg::BYTES_W-1:0] pixel_bytes_left;
  logic [CHUNK_W-1:0] chunk_position;
  logic stream_active;
  logic mul_pending;

  crfb_pkg::res_t out_res, skid_res, r;
  logic out_valid, skid_valid;
  logic r_valid;

  logic in_fire, is_start, is_pull;

  assign req.ready = !skid_valid;
  assign in_fire = req.valid && req.ready;
  assign is_start = in_fire && (req.cmd == crfb_pkg::CMD_START);
  assign is_pull = in_fire && (req.cmd == crfb_pkg::CMD_PULL);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width <= crfb_pkg::PANEL_WIDTH_RST;
      panel_height <= crfb_pkg::PANEL_HEIGHT_RST;
    end else if (wr_en) begin
      case (wr_index)
        crfb_pkg::REG_PANEL_WIDTH: panel_width <= wr_data;
        crfb_pkg::REG_PANEL_HEIGHT: panel_height <= wr_data;
        default: ;
      endcase
    end
  end

  // clipping, 19-bit signed holds every intermediate sum
  logic signed [SW-1:0] x0, y0, w0, h0, x1, y1, w1, h1, w2, h2, pws, phs;
  logic clip_empty;

  always_comb begin
    x0 = SW'(req.rect_x);
    y0 = SW'(req.rect_y);
    w0 = SW'(req.rect_w);
    h0 = SW'(req.rect_h);
    pws = $signed({{(SW-PW){1'b0}}, panel_width});
    phs = $signed({{(SW-PW){1'b0}}, panel_height});
    if (x0 < 0) begin
      w1 = w0 + x0;
      x1 = '0;
    end else begin
      w1 = w0;
      x1 = x0;
    end
    if (y0 < 0) begin
      h1 = h0 + y0;
      y1 = '0;
    end else begin
      h1 = h0;
      y1 = y0;
    end
    w2 = (x1 + w1 > pws) ? pws - x1 : w1;
    h2 = (y1 + h1 > phs) ? phs - y1 : h1;
    clip_empty = (w2 <= 0) || (h2 <= 0);
  end

  logic signed [SW-1:0] x_end, y_end;
  assign x_end = x1 + w2 - SW'(1);
  assign y_end = y1 + h2 - SW'(1);

  // next byte of the stream
  logic [crfb_pkg::BYTES_W-1:0] left_next;
  logic chunk_wrap;

  assign left_next = (pixel_bytes_left != '0) ? pixel_bytes_left - 1'b1 : pixel_bytes_left;
  assign chunk_wrap = (chunk_position == CHUNK_LAST);

  always_comb begin
    r = '0;
    r_valid = is_pull;
    if (!stream_active) begin
      r.idle = 1'b1;
    end else if (header_step != HDR_DONE) begin
      case (header_step)
        HDR_CASET: r.out_byte = crfb_pkg::DCS_CASET;
        HDR_XS_HI: r.out_byte = 8'(col_start >> 8);
        HDR_XS_LO: r.out_byte = col_start[7:0];
        HDR_XE_HI: r.out_byte = 8'(col_end >> 8);
        HDR_XE_LO: r.out_byte = col_end[7:0];
        HDR_RASET: r.out_byte = crfb_pkg::DCS_RASET;
        HDR_YS_HI: r.out_byte = 8'(row_start >> 8);
        HDR_YS_LO: r.out_byte = row_start[7:0];
        HDR_YE_HI: r.out_byte = 8'(row_end >> 8);
        HDR_YE_LO: r.out_byte = row_end[7:0];
        default: r.out_byte = crfb_pkg::DCS_RAMWR;
      endcase
      r.is_data = !(header_step == HDR_CASET || header_step == HDR_RASET ||
                    header_step == HDR_RAMWR);
      r.select_release = (header_step == HDR_XE_LO || header_step == HDR_YE_LO ||
                          header_step == HDR_RAMWR);
    end else begin
      // even count left means the high colour byte is next
      r.out_byte = pixel_bytes_left[0] ? held_colour[7:0] : held_colour[15:8];
      r.is_data = 1'b1;
      r.select_release = chunk_wrap || (left_next == '0);
      r.last_byte = (left_next == '0);
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_active <= 1'b0;
      header_step <= '0;
      mul_pending <= 1'b0;
    end else if (is_start) begin
      stream_active <= !clip_empty;
      header_step <= HDR_CASET;
      mul_pending <= !clip_empty;
    end else begin
      mul_pending <= 1'b0;
      if (is_pull && stream_active) begin
        if (header_step != HDR_DONE) begin
          header_step <= header_step + 1'b1;
        end else if (left_next == '0) begin
          stream_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_start && !clip_empty) begin
      col_start <= x1[PW-1:0];
      col_end <= x_end[PW-1:0];
      row_start <= y1[PW-1:0];
      row_end <= y_end[PW-1:0];
      clip_w <= w2[PW-1:0];
      clip_h <= h2[PW-1:0];
      held_colour <= req.fill_colour;
      chunk_position <= '0;
    end else if (is_pull && stream_active && header_step == HDR_DONE) begin
      chunk_position <= chunk_wrap ? '0 : chunk_position + 1'b1;
    end
    // byte count is multiplied out in the cycle after the start, from the registered clip size
    if (mul_pending) begin
      pixel_bytes_left <= {(2*PW)'(clip_w) * (2*PW)'(clip_h), 1'b0};
    end else if (is_pull && stream_active && header_step == HDR_DONE) begin
      pixel_bytes_left <= left_next;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      out_valid <= skid_valid || r_valid;
      skid_valid <= 1'b0;
    end else if (r_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || res.ready) begin
      out_res <= skid_valid ? skid_res : r;
    end else if (r_valid) begin
      skid_res <= r;
    end
  end

  assign res.valid = out_valid;
  assign res.out_byte = out_res.out_byte;
  assign res.is_data = out_res.is_data;
  assign res.select_release = out_res.select_release;
  assign res.last_byte = out_res.last_byte;
  assign res.idle = out_res.idle;

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    header_step <= HDR_DONE)
    else $error("header step past the end of the header");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a beat while the result register is empty");

  a_count_ready: assert property (@(posedge clk) disable iff (rst)
    stream_active && header_step == HDR_DONE |-> !mul_pending && pixel_bytes_left != '0)
    else $error("pixel phase reached without a byte count");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    is_pull && r.last_byte |=> !stream_active)
    else $error("stream still active after its last byte");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> (!out_valid || res.ready || !skid_valid))
    else $error("result produced with both output stages full");

endmodule
